// ===== rtl/cspm_pkg.sv =====
// Shared types and constants for the call-signaling message parser.
package cspm_pkg;

    localparam int BYTE_W = 8;
    localparam int REQ_W  = 2;

    // Default upper bound on an accepted error code.
    localparam logic [BYTE_W-1:0] MAX_ERROR_CODE = 8'd7;

    // Output tdata width: 21 field bits padded to whole bytes.
    localparam int RESULT_BITS = 1 + REQ_W + 1 + BYTE_W + 1 + BYTE_W;
    localparam int OUT_DATA_W  = ((RESULT_BITS + 7) / 8) * 8;

    // One payload byte handed from the input register to the parser.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } t_step;

    // One verdict produced on the final byte.
    typedef struct packed {
        logic [BYTE_W-1:0] capability_bits;
        logic              caps_present;
        logic [BYTE_W-1:0] error_code;
        logic              error_present;
        logic [REQ_W-1:0]  request_code;
        logic              parse_ok;
    } t_result;

endpackage

// ===== rtl/call_signal_message_parser.sv =====
// The verdict on the final byte is offered from the result register.
// Throughput: one byte per cycle; the input stalls only while a final byte waits behind
// an untaken verdict in the result register.
// Reset: synchronous active-low i_rst_n clears the input and result valid flags and all
// parse state; the block is ready for a new message in the cycle after reset drops.
module call_signal_message_parser #(
    parameter logic [7:0] MAX_ERROR_CODE = cspm_pkg::MAX_ERROR_CODE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: byte_value [7:0]
    input  logic [cspm_pkg::BYTE_W-1:0]       i_s_tdata,
    // tlast: last_byte
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: parse_ok [0], request_code [2:1], error_present [3], error_code [11:4],
    // caps_present [12], capability_bits [20:13], zero padding [23:21]
    output logic [cspm_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import cspm_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;

    logic    advance;
    t_step   step;
    logic    res_valid;
    t_result res;

    // The held byte moves on unless it is a final byte blocked by a full result register.
    assign advance    = !r_in_last || !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    assign step.valid      = r_in_valid && advance;
    assign step.byte_value = r_in_byte;
    assign step.last_byte  = r_in_last;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    cspm_parse #(
        .MAX_ERROR_CODE(MAX_ERROR_CODE)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - RESULT_BITS){1'b0}}, r_out};

endmodule

// ===== rtl/cspm_parse.sv =====
// Header decoder: per-message parse state and verdict logic.
module cspm_parse #(
    parameter logic [7:0] MAX_ERROR_CODE = cspm_pkg::MAX_ERROR_CODE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cspm_pkg::t_step  i_step,
    output logic             o_result_valid,
    output cspm_pkg::t_result o_result
);
    import cspm_pkg::*;

    typedef enum logic [1:0] {
        PH_ID,
        PH_SIZE,
        PH_VALUE
    } t_phase;

    localparam logic [1:0] HDR_REQUEST = 2'd1;
    localparam logic [1:0] HDR_ERROR   = 2'd2;
    localparam logic [BYTE_W-1:0] HDR_CAPS    = 8'd3;
    localparam logic [BYTE_W-1:0] REQUEST_MAX = 8'd2;
    localparam logic [BYTE_W-1:0] SIZE_ONE    = 8'd1;

    t_phase            r_phase, n_phase;
    logic [1:0]        r_cur_id, n_cur_id;
    logic              r_failed, n_failed;
    logic              r_ended, n_ended;
    logic              r_req_seen, n_req_seen;
    logic [REQ_W-1:0]  r_req_held, n_req_held;
    logic              r_err_seen, n_err_seen;
    logic [BYTE_W-1:0] r_err_held, n_err_held;
    logic              r_caps_seen, n_caps_seen;
    logic [BYTE_W-1:0] r_caps_held, n_caps_held;

    logic [BYTE_W-1:0] b;
    logic              ok;

    assign b = i_step.byte_value;

    // Advance the header state for one byte and form the verdict.
    always_comb begin
        n_phase     = r_phase;
        n_cur_id    = r_cur_id;
        n_failed    = r_failed;
        n_ended     = r_ended;
        n_req_seen  = r_req_seen;
        n_req_held  = r_req_held;
        n_err_seen  = r_err_seen;
        n_err_held  = r_err_held;
        n_caps_seen = r_caps_seen;
        n_caps_held = r_caps_held;

        if (!r_failed && !r_ended) begin
            case (r_phase)
                PH_ID: begin
                    if (b == '0) begin
                        n_ended = 1'b1;
                    end else if (b > HDR_CAPS) begin
                        n_failed = 1'b1;
                    end else begin
                        n_cur_id = b[1:0];
                        n_phase  = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    if (b != SIZE_ONE || i_step.last_byte) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    if (i_step.last_byte) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = PH_ID;
                        if (r_cur_id == HDR_REQUEST) begin
                            if (b > REQUEST_MAX) begin
                                n_failed = 1'b1;
                            end else begin
                                n_req_seen = 1'b1;
                                n_req_held = b[REQ_W-1:0];
                            end
                        end else if (r_cur_id == HDR_ERROR) begin
                            if (b > MAX_ERROR_CODE) begin
                                n_failed = 1'b1;
                            end else begin
                                n_err_seen = 1'b1;
                                n_err_held = b;
                            end
                        end else begin
                            n_caps_seen = 1'b1;
                            n_caps_held = b;
                        end
                    end
                end
            endcase
        end

        // Verdict from the updated state; all fields read zero on a failure.
        ok = !n_failed && n_ended && (b == '0) && n_req_seen;
        o_result                 = '0;
        o_result.parse_ok        = ok;
        if (ok) begin
            o_result.request_code    = n_req_held;
            o_result.error_present   = n_err_seen;
            o_result.error_code      = n_err_held;
            o_result.caps_present    = n_caps_seen;
            o_result.capability_bits = n_caps_held;
        end
    end

    assign o_result_valid = i_step.valid && i_step.last_byte;

    // State registers; the final byte returns everything to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last_byte)) begin
            r_phase     <= PH_ID;
            r_cur_id    <= '0;
            r_failed    <= 1'b0;
            r_ended     <= 1'b0;
            r_req_seen  <= 1'b0;
            r_req_held  <= '0;
            r_err_seen  <= 1'b0;
            r_err_held  <= '0;
            r_caps_seen <= 1'b0;
            r_caps_held <= '0;
        end else if (i_step.valid) begin
            r_phase     <= n_phase;
            r_cur_id    <= n_cur_id;
            r_failed    <= n_failed;
            r_ended     <= n_ended;
            r_req_seen  <= n_req_seen;
            r_req_held  <= n_req_held;
            r_err_seen  <= n_err_seen;
            r_err_held  <= n_err_held;
            r_caps_seen <= n_caps_seen;
            r_caps_held <= n_caps_held;
        end
    end

endmodule
